>>> src/dtcr_pkg.sv
package dtcr_pkg;

	localparam int DEF_GRID_WIDTH  = 128;
	localparam int DEF_GRID_HEIGHT = 64;

	localparam int KIND_W  = 3;
	localparam int COORD_W = 12;
	localparam int GLYPH_W = 8;
	localparam int DEPTH_W = 16;
	localparam int COUNT_W = 14;
	localparam int POS_W   = 14;
	localparam int ERR_W   = 16;
	localparam int WORD_W  = GLYPH_W + DEPTH_W;

	localparam int COUNT_MAX = 16383;

	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POINT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LINE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RECT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

	localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'h20;
	localparam logic [DEPTH_W-1:0] FAR_DEPTH   = 16'hFFFF;

	typedef struct packed {
		logic load;
		logic clr_en;
		logic skip;
		logic issue;
		logic rd_en;
		logic test;
		logic publish;
	} dtcr_cmd_t;

	typedef struct packed {
		logic pend;
		logic fin;
		logic clr_last;
	} dtcr_stat_t;

endpackage

>>> src/dtcr_cmd_if.sv
interface dtcr_cmd_if import dtcr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [KIND_W-1:0]          kind;
	logic signed [COORD_W-1:0]  x_start;
	logic signed [COORD_W-1:0]  y_start;
	logic signed [COORD_W-1:0]  x_end;
	logic signed [COORD_W-1:0]  y_end;
	logic [GLYPH_W-1:0]         glyph;
	logic [DEPTH_W-1:0]         depth;

	modport source (output valid, kind, x_start, y_start, x_end, y_end, glyph, depth,
		input ready);
	modport sink (input valid, kind, x_start, y_start, x_end, y_end, glyph, depth,
		output ready);
endinterface

>>> src/dtcr_res_if.sv
interface dtcr_res_if import dtcr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [GLYPH_W-1:0] glyph_out;
	logic [DEPTH_W-1:0] depth_out;
	logic [COUNT_W-1:0] cells_written;

	modport source (output valid, glyph_out, depth_out, cells_written, input ready);
	modport sink (input valid, glyph_out, depth_out, cells_written, output ready);
endinterface

>>> src/depth_tested_char_raster.sv
// each accepted command ends in one result beat; a line walks max(|dx|,|dy|)+1 cells, a rect
// outline its border cells, and a clear all GRID_WIDTH*GRID_HEIGHT cells
// one command at a time, each cell taking an address, read and test-and-write step in turn on
// the single-port cell memory; the next command is taken while a result waits
// reset: a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells (8192 by default) fills the grid
// with blanks at the farthest depth, and no command is taken until it ends
module depth_tested_char_raster import dtcr_pkg::*; #(
	parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
	parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
	input logic       clk,
	input logic       arst_n,
	dtcr_cmd_if.sink  cmd,
	dtcr_res_if.source res
);

	dtcr_cmd_t  dp_cmd;
	dtcr_stat_t dp_stat;

	dtcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.kind      (cmd.kind),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	dtcr_datapath #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.stat          (dp_stat),
		.kind          (cmd.kind),
		.x_start       (cmd.x_start),
		.y_start       (cmd.y_start),
		.x_end         (cmd.x_end),
		.y_end         (cmd.y_end),
		.glyph         (cmd.glyph),
		.depth         (cmd.depth),
		.glyph_out     (res.glyph_out),
		.depth_out     (res.depth_out),
		.cells_written (res.cells_written)
	);

endmodule

>>> src/dtcr_ctrl.sv
module dtcr_ctrl import dtcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] kind,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  dtcr_stat_t        stat,
	output dtcr_cmd_t         cmd
);

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_CLR  = 3'd2;
	localparam logic [2:0] S_GEN  = 3'd3;
	localparam logic [2:0] S_ADDR = 3'd4;
	localparam logic [2:0] S_READ = 3'd5;
	localparam logic [2:0] S_TEST = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = (kind == KIND_CLEAR) ? S_CLR : S_GEN;
				end
			end
			S_CLR: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_last) begin
					state_nxt = S_FIN;
				end
			end
			S_GEN: begin
				priority if (stat.pend) begin
					state_nxt = S_ADDR;
				end else if (stat.fin) begin
					state_nxt = S_FIN;
				end else begin
					cmd.skip = 1'b1;
				end
			end
			S_ADDR: begin
				cmd.issue = 1'b1;
				state_nxt = S_READ;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_TEST;
			end
			S_TEST: begin
				cmd.test = 1'b1;
				priority if (stat.pend) begin
					state_nxt = S_ADDR;
				end else if (stat.fin) begin
					state_nxt = S_FIN;
				end else begin
					state_nxt = S_GEN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_issue_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> cmd.rd_en)
		else $error("address issue not followed by memory read");

	a_read_test: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> cmd.test)
		else $error("memory read not followed by depth test");

	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == KIND_CLEAR) |=> cmd.clr_en)
		else $error("clear beat did not start the sweep");

	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid_q)
		else $error("published result not presented");

endmodule

>>> src/dtcr_datapath.sv
module dtcr_datapath import dtcr_pkg::*; #(
	parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
	parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dtcr_cmd_t                 cmd,
	output dtcr_stat_t                stat,
	input  logic [KIND_W-1:0]         kind,
	input  logic signed [COORD_W-1:0] x_start,
	input  logic signed [COORD_W-1:0] y_start,
	input  logic signed [COORD_W-1:0] x_end,
	input  logic signed [COORD_W-1:0] y_end,
	input  logic [GLYPH_W-1:0]        glyph,
	input  logic [DEPTH_W-1:0]        depth,
	output logic [GLYPH_W-1:0]        glyph_out,
	output logic [DEPTH_W-1:0]        depth_out,
	output logic [COUNT_W-1:0]        cells_written
);

	localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW          = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int XW          = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
	localparam int YW          = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
	localparam int CLEAR_COUNT = (CELLS > COUNT_MAX) ? COUNT_MAX : CELLS;
	localparam int E2W         = ERR_W + 1;

	localparam logic signed [POS_W-1:0] ONE_P = 1;
	localparam logic signed [POS_W-1:0] NEG_P = -1;
	localparam logic signed [POS_W-1:0] W_LIM = POS_W'(GRID_WIDTH);
	localparam logic signed [POS_W-1:0] H_LIM = POS_W'(GRID_HEIGHT);
	localparam logic [WORD_W-1:0] BLANK_WORD  = {BLANK_GLYPH, FAR_DEPTH};

	logic [WORD_W-1:0] mem [CELLS];

	logic [KIND_W-1:0]        mode_q;
	logic                     done_q;
	logic                     ph_q;
	logic                     sec_q;
	logic [AW-1:0]            clr_addr_q;
	logic signed [POS_W-1:0]  x_q, y_q, xe_q, ye_q, xl_q, yl_q, dx_q, dy_q;
	logic                     sx_q, sy_q;
	logic signed [ERR_W-1:0]  err_q;
	logic [COORD_W-1:0]       i_q;
	logic [GLYPH_W-1:0]       glyph_q;
	logic [DEPTH_W-1:0]       depth_q;
	logic [AW-1:0]            addr_q;
	logic                     inb_q;
	logic [WORD_W-1:0]        rdata_q;
	logic [COUNT_W-1:0]       cnt_q;
	logic [GLYPH_W-1:0]       rglyph_q;
	logic [DEPTH_W-1:0]       rdepth_q;
	logic [GLYPH_W-1:0]       glyph_out_q;
	logic [DEPTH_W-1:0]       depth_out_q;
	logic [COUNT_W-1:0]       cnt_out_q;

	logic signed [POS_W-1:0]  xs_c, ys_c, xe_c, ye_c, dx_c, dy_c;
	logic signed [POS_W-1:0]  i_s, px, py;
	logic                     inb;
	logic                     rect_more;
	logic signed [E2W-1:0]    e2, ndy, dxe;
	logic                     step_x, step_y;
	logic                     wr_en;

	// input decode
	assign xs_c = POS_W'(x_start);
	assign ys_c = POS_W'(y_start);
	assign xe_c = POS_W'(x_end);
	assign ye_c = POS_W'(y_end);
	assign dx_c = (xe_c > xs_c) ? (xe_c - xs_c) : (xs_c - xe_c);
	assign dy_c = (ye_c > ys_c) ? (ye_c - ys_c) : (ys_c - ye_c);

	// cell generator
	assign i_s       = signed'(POS_W'(i_q));
	assign rect_more = ph_q ? (i_s < (ye_q - ONE_P)) : (i_s < xe_q);

	always_comb begin
		if (mode_q == KIND_RECT) begin
			if (!ph_q) begin
				px = x_q + i_s;
				py = sec_q ? yl_q : y_q;
			end else begin
				px = sec_q ? xl_q : x_q;
				py = y_q + i_s;
			end
		end else begin
			px = x_q;
			py = y_q;
		end
	end

	assign inb = (px >= 0) && (px < W_LIM) && (py >= 0) && (py < H_LIM);

	assign stat.pend     = !done_q && ((mode_q != KIND_RECT) || rect_more);
	assign stat.fin      = done_q || ((mode_q == KIND_RECT) && ph_q && !rect_more);
	assign stat.clr_last = (clr_addr_q == AW'(CELLS - 1));

	// bresenham error walk
	assign e2     = {err_q, 1'b0};
	assign ndy    = -E2W'(dy_q);
	assign dxe    = E2W'(dx_q);
	assign step_x = (e2 > ndy);
	assign step_y = (e2 < dxe);

	assign wr_en = cmd.test && inb_q && (mode_q != KIND_READ) &&
		(depth_q <= rdata_q[DEPTH_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= KIND_CLEAR;
			done_q     <= 1'b1;
			ph_q       <= 1'b0;
			sec_q      <= 1'b0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.clr_en) begin
				clr_addr_q <= stat.clr_last ? '0 : clr_addr_q + AW'(1);
			end
			if (cmd.load) begin
				mode_q <= kind;
				done_q <= !((kind == KIND_POINT) || (kind == KIND_LINE) ||
					(kind == KIND_RECT) || (kind == KIND_READ));
				ph_q   <= 1'b0;
				sec_q  <= 1'b0;
			end else if (cmd.skip) begin
				if (mode_q == KIND_RECT && !ph_q) begin
					ph_q <= 1'b1;
				end
			end else if (cmd.issue) begin
				unique case (mode_q)
					KIND_RECT: sec_q <= !sec_q;
					KIND_LINE: done_q <= (x_q == xe_q) && (y_q == ye_q);
					default:   done_q <= 1'b1;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= xs_c;
			y_q     <= ys_c;
			xe_q    <= xe_c;
			ye_q    <= ye_c;
			xl_q    <= xs_c + xe_c - ONE_P;
			yl_q    <= ys_c + ye_c - ONE_P;
			dx_q    <= dx_c;
			dy_q    <= dy_c;
			sx_q    <= (xs_c < xe_c);
			sy_q    <= (ys_c < ye_c);
			err_q   <= ERR_W'(dx_c) - ERR_W'(dy_c);
			i_q     <= '0;
			glyph_q <= glyph;
			depth_q <= depth;
		end else if (cmd.skip) begin
			if (mode_q == KIND_RECT && !ph_q) begin
				i_q <= COORD_W'(1);
			end
		end else if (cmd.issue) begin
			if (mode_q == KIND_RECT && sec_q) begin
				i_q <= i_q + COORD_W'(1);
			end
			if (mode_q == KIND_LINE && !((x_q == xe_q) && (y_q == ye_q))) begin
				err_q <= err_q - (step_x ? ERR_W'(dy_q) : '0) + (step_y ? ERR_W'(dx_q) : '0);
				if (step_x) begin
					x_q <= x_q + (sx_q ? ONE_P : NEG_P);
				end
				if (step_y) begin
					y_q <= y_q + (sy_q ? ONE_P : NEG_P);
				end
			end
		end
		if (cmd.issue) begin
			addr_q <= AW'(py[YW-1:0]) * AW'(GRID_WIDTH) + AW'(px[XW-1:0]);
			inb_q  <= inb;
		end
	end

	// cell memory
	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			mem[clr_addr_q] <= BLANK_WORD;
		end else if (wr_en) begin
			mem[addr_q] <= {glyph_q, depth_q};
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[addr_q];
		end
	end

	// result assembly
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_q    <= (kind == KIND_CLEAR) ? COUNT_W'(CLEAR_COUNT) : '0;
			rglyph_q <= '0;
			rdepth_q <= FAR_DEPTH;
		end else if (cmd.test && inb_q) begin
			if (mode_q == KIND_READ) begin
				rglyph_q <= rdata_q[WORD_W-1:DEPTH_W];
				rdepth_q <= rdata_q[DEPTH_W-1:0];
			end else if (wr_en && cnt_q != COUNT_W'(COUNT_MAX)) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end
		end
		if (cmd.publish) begin
			glyph_out_q <= rglyph_q;
			depth_out_q <= rdepth_q;
			cnt_out_q   <= cnt_q;
		end
	end

	assign glyph_out     = glyph_out_q;
	assign depth_out     = depth_out_q;
	assign cells_written = cnt_out_q;

	a_sweep_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clr_en && stat.clr_last) |=> (clr_addr_q == '0))
		else $error("clear sweep did not wrap to the first cell");

	a_write_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_en && wr_en))
		else $error("plot write during clear sweep");

	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.test && mode_q == KIND_READ) |-> !wr_en)
		else $error("read command wrote a cell");

endmodule
